FILE: hw/rtl/arc_odometry_integrator_macros.svh
// ----------------------------------------------------------------------------
// Arc odometry integrator assertion macros
// Shared concurrent assertion forms for the integrator.
// ----------------------------------------------------------------------------
`ifndef ARC_ODOMETRY_INTEGRATOR_MACROS_SVH
`define ARC_ODOMETRY_INTEGRATOR_MACROS_SVH

// same-cycle implication
`define AOI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AOI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/aoi_pkg.sv
// ----------------------------------------------------------------------------
// Arc odometry integrator package
// Beat types, constants, controller ops and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package aoi_pkg;

  localparam int CORDIC_STEPS = 18;
  localparam int DIV_STEPS    = 55;
  localparam int WIDTH_W      = 23;

  localparam logic [22:0] WIDTH_RESET = 23'd983040;
  localparam logic signed [34:0] DEG_TO_TURN = 35'sd11930465;
  localparam logic signed [34:0] RAD_INV_Q16 = 35'sd3754936;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] right_distance;
    logic signed [31:0] heading_deg;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic               saturated;
  } out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_HALF,
    OP_MUL_LAST,
    OP_MUL_NUM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_RATIO,
    OP_COR_INIT_HALF,
    OP_COR_STEP,
    OP_COR_HALF_DONE,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_CHORD,
    OP_COR_INIT_MID,
    OP_COR_MID_DONE,
    OP_MUL_X,
    OP_POS_X,
    OP_POS_Y,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_cmd;
    logic dh_zero;
  } ctl_sts_t;

  function automatic logic [29:0] atan_turns(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/arc_odometry_integrator.sv
// ----------------------------------------------------------------------------
// Arc odometry integrator
// Dead reckoning from a cumulative wheel distance and a heading in degrees.
// ----------------------------------------------------------------------------
// One beat is taken at a time. An update beat runs the 55-step restoring
// divider for the arc radius and two 18-step CORDIC passes, all on one shared
// datapath with one multiplier, and skips the divider and the first pass when
// the heading does not change. A pose reset beat skips all the arithmetic.
// The result sits in an output register, so the next beat is taken while an
// earlier result is still held; a new result waits in the pose registers
// until the previous one has left. The user must write the track width
// through the cfg port only while no beat is in flight; it is not enforced.
module arc_odometry_integrator (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  aoi_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output aoi_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [22:0]   cfg_data
);

`include "arc_odometry_integrator_macros.svh"

  aoi_pkg::ctl_cmd_t cmd;
  aoi_pkg::ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  aoi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  aoi_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  `AOI_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "busy after beat")
  `AOI_ASSERT_IMPL(a_idle_on_result, $rose(out_valid), !in_stall, "not idle on result")
  `AOI_ASSERT_IMPL(a_load_only_idle, cmd.op == aoi_pkg::OP_LOAD, in_valid && !in_stall, "bad load")

endmodule

FILE: hw/rtl/aoi_ctrl.sv
// ----------------------------------------------------------------------------
// Arc odometry integrator controller
// Sequences the shared datapath through one update and owns both handshakes.
// ----------------------------------------------------------------------------
module aoi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  aoi_pkg::ctl_sts_t sts,
  output aoi_pkg::ctl_cmd_t cmd
);

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_MHALF  = 20'h00002,
    S_MLAST  = 20'h00004,
    S_MNUM   = 20'h00008,
    S_DINIT  = 20'h00010,
    S_DIV    = 20'h00020,
    S_RATIO  = 20'h00040,
    S_CHINIT = 20'h00080,
    S_CHSTEP = 20'h00100,
    S_CHDONE = 20'h00200,
    S_MLO    = 20'h00400,
    S_MHI    = 20'h00800,
    S_CHORD  = 20'h01000,
    S_CMINIT = 20'h02000,
    S_CMSTEP = 20'h04000,
    S_CMDONE = 20'h08000,
    S_MX     = 20'h10000,
    S_MY     = 20'h20000,
    S_PY     = 20'h40000,
    S_FIN    = 20'h80000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = aoi_pkg::OP_NONE;
    cmd.idx       = cnt_r[4:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = aoi_pkg::OP_LOAD;
          state_nxt = sts.in_cmd ? S_FIN : S_MHALF;
        end
      end
      S_MHALF: begin
        cmd.op    = aoi_pkg::OP_MUL_HALF;
        state_nxt = S_MLAST;
      end
      S_MLAST: begin
        cmd.op    = aoi_pkg::OP_MUL_LAST;
        state_nxt = S_MNUM;
      end
      S_MNUM: begin
        cmd.op    = aoi_pkg::OP_MUL_NUM;
        state_nxt = sts.dh_zero ? S_CMINIT : S_DINIT;
      end
      S_DINIT: begin
        cmd.op    = aoi_pkg::OP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = aoi_pkg::OP_DIV_STEP;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(aoi_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_RATIO;
        end
      end
      S_RATIO: begin
        cmd.op    = aoi_pkg::OP_RATIO;
        state_nxt = S_CHINIT;
      end
      S_CHINIT: begin
        cmd.op    = aoi_pkg::OP_COR_INIT_HALF;
        cnt_nxt   = '0;
        state_nxt = S_CHSTEP;
      end
      S_CHSTEP: begin
        cmd.op  = aoi_pkg::OP_COR_STEP;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(aoi_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = S_CHDONE;
        end
      end
      S_CHDONE: begin
        cmd.op    = aoi_pkg::OP_COR_HALF_DONE;
        state_nxt = S_MLO;
      end
      S_MLO: begin
        cmd.op    = aoi_pkg::OP_MUL_LO;
        state_nxt = S_MHI;
      end
      S_MHI: begin
        cmd.op    = aoi_pkg::OP_MUL_HI;
        state_nxt = S_CHORD;
      end
      S_CHORD: begin
        cmd.op    = aoi_pkg::OP_CHORD;
        state_nxt = S_CMINIT;
      end
      S_CMINIT: begin
        cmd.op    = aoi_pkg::OP_COR_INIT_MID;
        cnt_nxt   = '0;
        state_nxt = S_CMSTEP;
      end
      S_CMSTEP: begin
        cmd.op  = aoi_pkg::OP_COR_STEP;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(aoi_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = S_CMDONE;
        end
      end
      S_CMDONE: begin
        cmd.op    = aoi_pkg::OP_COR_MID_DONE;
        state_nxt = S_MX;
      end
      S_MX: begin
        cmd.op    = aoi_pkg::OP_MUL_X;
        state_nxt = S_MY;
      end
      S_MY: begin
        cmd.op    = aoi_pkg::OP_POS_X;
        state_nxt = S_PY;
      end
      S_PY: begin
        cmd.op    = aoi_pkg::OP_POS_Y;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = aoi_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/aoi_dpath.sv
// ----------------------------------------------------------------------------
// Arc odometry integrator datapath
// Shared multiplier, restoring divider, CORDIC rotator and pose registers.
// ----------------------------------------------------------------------------
module aoi_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  aoi_pkg::in_t      in_data,
  output aoi_pkg::out_t     out_data,
  input  logic              cfg_valid,
  input  logic [22:0]       cfg_data,
  input  aoi_pkg::ctl_cmd_t cmd,
  output aoi_pkg::ctl_sts_t sts
);

  logic [22:0]        width_r;
  logic signed [31:0] last_rd_r, last_hd_r, rd_r, hd_r;
  logic signed [31:0] pos_x_r, pos_y_r;
  logic signed [32:0] dr_r, dh_r;
  logic [31:0]        half_r, mid_r;
  logic [54:0]        num_r;
  logic [32:0]        rem_r, mh_r;
  logic [56:0]        ma_r;
  logic               qneg_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic [1:0]         quad_r;
  logic signed [33:0] s_r, sn_r, cs_r, chord_r;
  logic [64:0]        plo_r;
  logic               sat_r;
  logic signed [69:0] p_r;
  aoi_pkg::out_t      out_r;

  logic signed [34:0] mul_a, mul_b;
  logic [32:0]        mr, s_mag;
  logic [33:0]        trial;
  logic [54:0]        q_w;
  logic signed [56:0] qs;
  logic signed [33:0] xs, ys, cor_s, cor_c;
  logic               phi_big, clamp;
  logic [36:0]        r_w;
  logic [32:0]        mag;
  logic signed [39:0] dp;
  logic signed [40:0] psum;
  logic               povf;
  logic signed [31:0] pclip;
  logic signed [31:0] pos_sel;

  assign mr    = dr_r[32] ? 33'(-dr_r) : 33'(dr_r);
  assign s_mag = s_r[33] ? 33'(-s_r) : 33'(s_r);
  assign trial = {rem_r, num_r[54]};
  assign q_w   = num_r;
  assign qs    = (qneg_r ? -$signed({2'b00, q_w}) : $signed({2'b00, q_w}))
               + $signed({35'd0, width_r[22:1]});
  assign xs    = cx_r >>> cmd.idx;
  assign ys    = cy_r >>> cmd.idx;

  always_comb begin
    case (quad_r)
      2'd0: begin
        cor_c = cx_r;
        cor_s = cy_r;
      end
      2'd1: begin
        cor_c = -cy_r;
        cor_s = cx_r;
      end
      2'd2: begin
        cor_c = -cx_r;
        cor_s = -cy_r;
      end
      default: begin
        cor_c = cy_r;
        cor_s = -cx_r;
      end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      aoi_pkg::OP_MUL_HALF: begin
        mul_a = 35'(dh_r);
        mul_b = aoi_pkg::DEG_TO_TURN;
      end
      aoi_pkg::OP_MUL_LAST: begin
        mul_a = 35'(last_hd_r);
        mul_b = aoi_pkg::DEG_TO_TURN;
      end
      aoi_pkg::OP_MUL_NUM: begin
        mul_a = $signed({2'b00, mr});
        mul_b = aoi_pkg::RAD_INV_Q16;
      end
      aoi_pkg::OP_MUL_LO: begin
        mul_a = $signed({3'b000, ma_r[31:0]});
        mul_b = $signed({2'b00, s_mag});
      end
      aoi_pkg::OP_MUL_HI: begin
        mul_a = $signed({10'd0, ma_r[56:32]});
        mul_b = $signed({2'b00, s_mag});
      end
      aoi_pkg::OP_MUL_X: begin
        mul_a = 35'(chord_r);
        mul_b = 35'(sn_r);
      end
      aoi_pkg::OP_POS_X: begin
        mul_a = 35'(chord_r);
        mul_b = 35'(cs_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // chord magnitude from the two partial products
  assign phi_big = |p_r[69:29];
  assign r_w     = {2'b00, p_r[28:0], 3'b000} + {1'b0, plo_r[64:29]};
  assign clamp   = phi_big || (r_w > 37'h100000000);
  assign mag     = clamp ? 33'h100000000 : r_w[32:0];

  // saturating position add
  assign pos_sel = (cmd.op == aoi_pkg::OP_POS_X) ? pos_x_r : pos_y_r;
  assign dp      = p_r[69:30];
  assign psum    = 41'(pos_sel) + 41'(dp);
  assign povf    = (psum[40:31] != {10{psum[40]}});
  assign pclip   = povf ? (psum[40] ? 32'sh80000000 : 32'sh7fffffff) : psum[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= aoi_pkg::WIDTH_RESET;
      last_rd_r <= '0;
      last_hd_r <= '0;
      pos_x_r   <= '0;
      pos_y_r   <= '0;
    end else begin
      if (cfg_valid) begin
        width_r <= cfg_data;
      end
      case (cmd.op)
        aoi_pkg::OP_LOAD: begin
          if (in_data.cmd) begin
            pos_x_r   <= '0;
            pos_y_r   <= '0;
            last_rd_r <= in_data.right_distance;
            last_hd_r <= in_data.heading_deg;
          end
        end
        aoi_pkg::OP_POS_X: begin
          pos_x_r <= pclip;
        end
        aoi_pkg::OP_POS_Y: begin
          pos_y_r   <= pclip;
          last_rd_r <= rd_r;
          last_hd_r <= hd_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    case (cmd.op)
      aoi_pkg::OP_LOAD: begin
        rd_r  <= in_data.right_distance;
        hd_r  <= in_data.heading_deg;
        dr_r  <= 33'(in_data.right_distance) - 33'(last_rd_r);
        dh_r  <= 33'(in_data.heading_deg) - 33'(last_hd_r);
        sat_r <= 1'b0;
      end
      aoi_pkg::OP_MUL_LAST: begin
        half_r <= p_r[48:17];
      end
      aoi_pkg::OP_MUL_NUM: begin
        mid_r <= p_r[47:16] + half_r;
        if (dh_r == '0) begin
          chord_r <= 34'(dr_r);
        end
      end
      aoi_pkg::OP_DIV_INIT: begin
        num_r  <= p_r[54:0];
        rem_r  <= '0;
        mh_r   <= dh_r[32] ? 33'(-dh_r) : 33'(dh_r);
        qneg_r <= dr_r[32] ^ dh_r[32];
      end
      aoi_pkg::OP_DIV_STEP: begin
        if (trial >= {1'b0, mh_r}) begin
          rem_r <= 33'(trial - {1'b0, mh_r});
          num_r <= {num_r[53:0], 1'b1};
        end else begin
          rem_r <= trial[32:0];
          num_r <= {num_r[53:0], 1'b0};
        end
      end
      aoi_pkg::OP_RATIO: begin
        ma_r   <= qs[56] ? 57'(-qs) : 57'(qs);
        qneg_r <= qs[56];
      end
      aoi_pkg::OP_COR_INIT_HALF: begin
        cx_r   <= aoi_pkg::CORDIC_GAIN;
        cy_r   <= '0;
        cz_r   <= $signed({4'd0, half_r[29:0]});
        quad_r <= half_r[31:30];
      end
      aoi_pkg::OP_COR_INIT_MID: begin
        cx_r   <= aoi_pkg::CORDIC_GAIN;
        cy_r   <= '0;
        cz_r   <= $signed({4'd0, mid_r[29:0]});
        quad_r <= mid_r[31:30];
      end
      aoi_pkg::OP_COR_STEP: begin
        if (!cz_r[33]) begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - $signed({4'd0, aoi_pkg::atan_turns(cmd.idx)});
        end else begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + $signed({4'd0, aoi_pkg::atan_turns(cmd.idx)});
        end
      end
      aoi_pkg::OP_COR_HALF_DONE: begin
        s_r <= cor_s;
      end
      aoi_pkg::OP_MUL_HI: begin
        plo_r <= p_r[64:0];
      end
      aoi_pkg::OP_CHORD: begin
        chord_r <= (qneg_r ^ s_r[33]) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        if (clamp) begin
          sat_r <= 1'b1;
        end
      end
      aoi_pkg::OP_COR_MID_DONE: begin
        sn_r <= cor_s;
        cs_r <= cor_c;
      end
      aoi_pkg::OP_POS_X, aoi_pkg::OP_POS_Y: begin
        if (povf) begin
          sat_r <= 1'b1;
        end
      end
      aoi_pkg::OP_OUT: begin
        out_r.pos_x_out <= pos_x_r;
        out_r.pos_y_out <= pos_y_r;
        out_r.saturated <= sat_r;
      end
      default: begin
      end
    endcase
  end

  assign out_data    = out_r;
  assign sts.in_cmd  = in_data.cmd;
  assign sts.dh_zero = (dh_r == '0);

endmodule
